>>> hw/rtl/iir_df1_pkg.sv
// ----------------------------------------------------------------------------
// IIR Direct Form I package
// Widths, register map, payload types and the round/saturate function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iir_df1_pkg;

  localparam int SAMPLE_W = 16;  // Q1.15
  localparam int COEF_W   = 20;  // Q4.16
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = PROD_W + 2;  // five products
  localparam int FRAC_SHIFT = 16;
  localparam int RND_W    = ACC_W - FRAC_SHIFT;

  localparam int FEEDFORWARD_TAPS = 3;
  localparam int FEEDBACK_TAPS    = 2;

  localparam int NUM_REGS = 5;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic signed [COEF_W-1:0] COEF_B0_RESET = 20'sd65536;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(32768);
  localparam logic signed [RND_W-1:0] RND_MAX    = RND_W'(32767);
  localparam logic signed [RND_W-1:0] RND_MIN    = -RND_W'(32768);

  typedef enum logic [2:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_index_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  typedef struct packed {
    logic    saturated;
    sample_t sample_out;
  } out_item_t;

  // Round to nearest (ties up), then clip to the sample range.
  function automatic out_item_t round_sat(input acc_t acc);
    acc_t                     biased;
    logic signed [RND_W-1:0]  rnd;
    out_item_t                r;
    biased = acc + ROUND_BIAS;
    rnd    = RND_W'(biased >>> FRAC_SHIFT);
    if (rnd > RND_MAX) begin
      r.sample_out = SAMPLE_W'(RND_MAX);
      r.saturated  = 1'b1;
    end else if (rnd < RND_MIN) begin
      r.sample_out = SAMPLE_W'(RND_MIN);
      r.saturated  = 1'b1;
    end else begin
      r.sample_out = SAMPLE_W'(rnd);
      r.saturated  = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/iir_df1_tap.sv
// ----------------------------------------------------------------------------
// IIR Direct Form I tap cell
// Holds one history sample, weights it by its coefficient and passes the
// sample on to the next cell of the delay line on every transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iir_df1_tap
  import iir_df1_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  logic    clear,
  input  coef_t   coef,
  input  sample_t shift_in,
  output sample_t shift_out,
  output prod_t   product
);

  sample_t hist;

  // Cleared history reads as zero for the sample that requests the clear.
  assign shift_out = clear ? '0 : hist;
  assign product   = coef * shift_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (advance) begin
      hist <= shift_in;
    end
  end

endmodule

>>> hw/rtl/iir_df1_outbuf.sv
// ----------------------------------------------------------------------------
// IIR Direct Form I output buffer
// Two-entry result queue: a head register that drives the port and a skid
// register behind it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iir_df1_outbuf
  import iir_df1_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t push_item,
  output logic      push_ready,
  output logic      pop_valid,
  input  logic      pop_ready,
  output out_item_t head_item
);

  logic [1:0] count;
  logic [1:0] count_next;
  out_item_t  skid_item;
  logic       pop;

  assign pop        = pop_valid & pop_ready;
  assign pop_valid  = (count != 2'd0);
  assign push_ready = (count != 2'd2);

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Head takes the skid entry on a pop from full, or a push when free.
  always_ff @(posedge clk) begin
    if (pop && count == 2'd2) begin
      head_item <= skid_item;
    end else if (push && (count == 2'd0 || (count == 2'd1 && pop))) begin
      head_item <= push_item;
    end
    if (push && count == 2'd1 && !pop) begin
      skid_item <= push_item;
    end
  end

endmodule

>>> hw/rtl/iir_direct_form1_filter_core.sv
// ----------------------------------------------------------------------------
// IIR Direct Form I biquad filter core
// y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2, rounded and saturated to Q1.15.
//
//   port group   direction  payload
//   s_*          in         tdata: sample_in[15:0]; tuser: clear_history
//   m_*          out        tdata: sample_out[15:0]; tuser: saturated
//   p*           APB        coef_b0..coef_a2 at 0x00..0x10, 20 bits signed
//
// One sample per cycle while s_tready is high: the five products and their sum
// close the output feedback loop combinationally, registered in the tap cells.
// Each result is registered in the output queue when its input transfers.
// A two-entry output queue keeps the input open for one more sample while a
// result waits; s_tready drops only when both entries are full.
// Reset clears histories and queue and restores b0 = 1.0, other taps 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iir_direct_form1_filter_core
  import iir_df1_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample_in
  input  logic                s_tuser,   // [0] clear_history
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [SAMPLE_W-1:0] m_tdata,   // [15:0] sample_out
  output logic                m_tuser,   // [0] saturated
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  coef_t coef [NUM_REGS];

  logic       advance;
  logic       clear;
  logic       cfg_write;
  reg_index_t cfg_index;
  sample_t    x;
  sample_t    x1;
  sample_t    x2;
  sample_t    y1;
  sample_t    y2;
  prod_t      prod_b0;
  prod_t      prod_b1;
  prod_t      prod_b2;
  prod_t      prod_a1;
  prod_t      prod_a2;
  acc_t       acc;
  out_item_t  result;
  out_item_t  head_item;

  // ---- configuration ----
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign cfg_index = reg_index_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef[REG_B0] <= COEF_B0_RESET;
      coef[REG_B1] <= '0;
      coef[REG_B2] <= '0;
      coef[REG_A1] <= '0;
      coef[REG_A2] <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_B0:  coef[REG_B0] <= pwdata[COEF_W-1:0];
        REG_B1:  coef[REG_B1] <= pwdata[COEF_W-1:0];
        REG_B2:  coef[REG_B2] <= pwdata[COEF_W-1:0];
        REG_A1:  coef[REG_A1] <= pwdata[COEF_W-1:0];
        REG_A2:  coef[REG_A2] <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_B0:  prdata = DATA_W'(coef[REG_B0]);
      REG_B1:  prdata = DATA_W'(coef[REG_B1]);
      REG_B2:  prdata = DATA_W'(coef[REG_B2]);
      REG_A1:  prdata = DATA_W'(coef[REG_A1]);
      REG_A2:  prdata = DATA_W'(coef[REG_A2]);
      default: prdata = '0;
    endcase
  end

  // ---- datapath ----
  assign advance = s_tvalid & s_tready;
  assign clear   = s_tuser;
  assign x       = s_tdata;
  assign prod_b0 = coef[REG_B0] * x;

  iir_df1_tap u_tap_x1 (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .clear     (clear),
    .coef      (coef[REG_B1]),
    .shift_in  (x),
    .shift_out (x1),
    .product   (prod_b1)
  );

  iir_df1_tap u_tap_x2 (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .clear     (clear),
    .coef      (coef[REG_B2]),
    .shift_in  (x1),
    .shift_out (x2),
    .product   (prod_b2)
  );

  iir_df1_tap u_tap_y1 (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .clear     (clear),
    .coef      (coef[REG_A1]),
    .shift_in  (result.sample_out),
    .shift_out (y1),
    .product   (prod_a1)
  );

  iir_df1_tap u_tap_y2 (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .clear     (clear),
    .coef      (coef[REG_A2]),
    .shift_in  (y1),
    .shift_out (y2),
    .product   (prod_a2)
  );

  // Drop taps beyond the configured order; histories still shift.
  always_comb begin
    acc = ACC_W'(prod_b0);
    if (FEEDFORWARD_TAPS >= 2) begin
      acc = acc + ACC_W'(prod_b1);
    end
    if (FEEDFORWARD_TAPS >= 3) begin
      acc = acc + ACC_W'(prod_b2);
    end
    if (FEEDBACK_TAPS >= 1) begin
      acc = acc - ACC_W'(prod_a1);
    end
    if (FEEDBACK_TAPS >= 2) begin
      acc = acc - ACC_W'(prod_a2);
    end
  end

  assign result = round_sat(acc);

  // ---- output queue ----
  iir_df1_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .push       (advance),
    .push_item  (result),
    .push_ready (s_tready),
    .pop_valid  (m_tvalid),
    .pop_ready  (m_tready),
    .head_item  (head_item)
  );

  assign m_tdata = head_item.sample_out;
  assign m_tuser = head_item.saturated;

endmodule
